>>> src/kmp_pkg.sv
`timescale 1ns / 1ps

package kmp_pkg;

  // Fixed field widths
  localparam int PRICE_W  = 16;
  localparam int PROFIT_W = 31;
  localparam int KCFG_W   = 7;
  localparam int COUNT_W  = 17;
  localparam int HOLD_W   = 33;

  // Default number of stages
  localparam int MAX_K_DEF = 64;

  localparam logic [PROFIT_W-1:0] PROFIT_CAP = {PROFIT_W{1'b1}};
  localparam logic [COUNT_W-1:0]  COUNT_CAP  = {COUNT_W{1'b1}};
  // -2^32: no share held yet
  localparam logic signed [HOLD_W-1:0] NO_HOLD = {1'b1, {(HOLD_W-1){1'b0}}};

  // Per-cycle control for the stage chain
  typedef struct packed {
    logic en;   // update on this price
    logic clr;  // return to the cleared state
  } cell_ctrl_t;

endpackage

>>> src/kmp_ifs.sv
`timescale 1ns / 1ps

// Price request channel
interface kmp_price_if;
  logic                        valid;
  logic                        ready;
  logic [kmp_pkg::PRICE_W-1:0] price;
  logic                        last_price;

  modport source (output valid, output price, output last_price, input ready);
  modport sink   (input valid, input price, input last_price, output ready);
endinterface

// Profit result channel
interface kmp_profit_if;
  logic                         valid;
  logic                         ready;
  logic [kmp_pkg::PROFIT_W-1:0] best_profit;

  modport source (output valid, output best_profit, input ready);
  modport sink   (input valid, input best_profit, output ready);
endinterface

// Configuration write channel
interface kmp_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [kmp_pkg::KCFG_W-1:0] max_transactions;

  modport source (output valid, output max_transactions, input ready);
  modport sink   (input valid, input max_transactions, output ready);
endinterface

>>> src/k_transaction_max_profit_top.sv
`timescale 1ns / 1ps

// Channel    Dir  Payload                     Request taken when
// price_i    in   price[15:0], last_price     valid && ready
// profit_o   out  best_profit[30:0]           valid && ready
// cfg_i      in   max_transactions[6:0]       valid && ready (ready always high)
//
// One price per cycle while price ready is high: all MAX_K stage cells update
// together, each from its neighbor's sold value of the previous cycle.
// After a last price the block enters a finish state (ready low) in which the
// result is picked from the stage chain and the cells clear; the finish waits
// while an earlier result sits in the output register and is not taken.
// Reset zeroes the counters, max_transactions and sold values; holds go to NO_HOLD.
module k_transaction_max_profit_top #(
  parameter int MAX_K = kmp_pkg::MAX_K_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  kmp_price_if.sink    price_i,
  kmp_profit_if.source profit_o,
  kmp_cfg_if.sink      cfg_i
);
  import kmp_pkg::*;

  localparam int KW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int KCW = $clog2(MAX_K + 1);

  typedef enum logic {ST_RUN, ST_FINISH} st_e;

  st_e                  state_q;
  logic                 out_valid_q;
  logic [PROFIT_W-1:0]  profit_q;
  logic [KCFG_W-1:0]    kcfg_q;
  logic [COUNT_W-1:0]   count_q;
  logic [PRICE_W-1:0]   prev_q;
  logic [PROFIT_W-1:0]  rise_q;

  logic                 accept;
  logic                 finish;
  cell_ctrl_t           ctrl;
  logic [PROFIT_W-1:0]  sold [MAX_K];
  logic [PROFIT_W:0]    rise_sum;
  logic [KCW-1:0]       k_eff;
  logic [PROFIT_W-1:0]  result;

  assign price_i.ready = (state_q == ST_RUN);
  assign accept        = price_i.valid && price_i.ready;
  assign finish        = (state_q == ST_FINISH) && (!out_valid_q || profit_o.ready);
  assign ctrl.en       = accept;
  assign ctrl.clr      = finish;

  // Stage chain; stage 0 buys from a constant zero
  for (genvar j = 0; j < MAX_K; j++) begin : g_cell
    logic [PROFIT_W-1:0] below;
    if (j == 0) begin : g_first
      assign below = '0;
    end else begin : g_rest
      assign below = sold[j-1];
    end
    kmp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .price_i (price_i.price),
      .below_i (below),
      .sold_o  (sold[j])
    );
  end

  // Saturating sum of price rises
  assign rise_sum = {1'b0, rise_q}
                  + {{(PROFIT_W+1-PRICE_W){1'b0}}, price_i.price - prev_q};

  // Result from registered state during the finish cycle
  always_comb begin
    k_eff = (int'(kcfg_q) > MAX_K) ? KCW'(MAX_K) : KCW'(kcfg_q);
    if (k_eff == '0 || count_q < COUNT_W'(2)) begin
      result = '0;
    end else if (32'(k_eff) >= 32'(count_q >> 1)) begin
      result = rise_q;
    end else begin
      result = sold[KW'(k_eff - KCW'(1))];
    end
  end

  // Configuration register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kcfg_q <= '0;
    end else if (cfg_i.valid) begin
      kcfg_q <= cfg_i.max_transactions;
    end
  end

  // Price count, previous price and rise sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      prev_q  <= '0;
      rise_q  <= '0;
    end else if (finish) begin
      count_q <= '0;
      prev_q  <= '0;
      rise_q  <= '0;
    end else if (accept) begin
      if (count_q != '0 && price_i.price > prev_q) begin
        rise_q <= rise_sum[PROFIT_W] ? PROFIT_CAP : rise_sum[PROFIT_W-1:0];
      end
      prev_q <= price_i.price;
      if (count_q != COUNT_CAP) begin
        count_q <= count_q + COUNT_W'(1);
      end
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
      profit_q    <= '0;
    end else begin
      // a finishing result replaces one taken in the same cycle
      if (finish) begin
        out_valid_q <= 1'b1;
        profit_q    <= result;
      end else if (out_valid_q && profit_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_RUN: begin
          if (accept && price_i.last_price) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (finish) begin
            state_q <= ST_RUN;
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

  assign profit_o.valid       = out_valid_q;
  assign profit_o.best_profit = profit_q;

endmodule

>>> src/kmp_cell.sv
`timescale 1ns / 1ps

// One transaction stage: best holding value and best sold value
module kmp_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kmp_pkg::cell_ctrl_t           ctrl_i,
  input  logic [kmp_pkg::PRICE_W-1:0]   price_i,
  input  logic [kmp_pkg::PROFIT_W-1:0]  below_i,
  output logic [kmp_pkg::PROFIT_W-1:0]  sold_o
);
  import kmp_pkg::*;

  logic signed [HOLD_W-1:0]   hold_q, hold_d;
  logic        [PROFIT_W-1:0] sold_q, sold_d;
  logic signed [HOLD_W-1:0]   buy;
  logic signed [HOLD_W:0]     sell;
  logic signed [HOLD_W-1:0]   hold_new;

  // Buy from the lower stage's old sold value, then try selling today
  always_comb begin
    buy      = $signed({2'b00, below_i}) - $signed({{(HOLD_W-PRICE_W){1'b0}}, price_i});
    hold_new = (hold_q < buy) ? buy : hold_q;
    sell     = $signed({hold_new[HOLD_W-1], hold_new})
             + $signed({{(HOLD_W+1-PRICE_W){1'b0}}, price_i});
    hold_d   = hold_q;
    sold_d   = sold_q;
    if (ctrl_i.clr) begin
      hold_d = NO_HOLD;
      sold_d = '0;
    end else if (ctrl_i.en) begin
      hold_d = hold_new;
      if (sell > $signed({3'b000, sold_q})) begin
        sold_d = (sell > $signed({3'b000, PROFIT_CAP})) ? PROFIT_CAP : sell[PROFIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= NO_HOLD;
      sold_q <= '0;
    end else begin
      hold_q <= hold_d;
      sold_q <= sold_d;
    end
  end

  assign sold_o = sold_q;

endmodule

>>> src/kmp_checker.sv
`timescale 1ns / 1ps

// Port-level checks for the profit block
module kmp_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_last,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [kmp_pkg::PROFIT_W-1:0]  out_profit
);

  // An accepted last price is always followed by a busy finish state
  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input ready right after a last price");

  // A new result only appears out of a finish cycle
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a finish cycle");

  // Stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_profit))
    else $error("stalled result changed");

  // No result during reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid)
    else $error("result valid during reset");

endmodule

bind k_transaction_max_profit_top kmp_checker u_kmp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (price_i.valid),
  .in_ready   (price_i.ready),
  .in_last    (price_i.last_price),
  .out_valid  (profit_o.valid),
  .out_ready  (profit_o.ready),
  .out_profit (profit_o.best_profit)
);
